FILE: rtl/sfdl_pkg.sv
// Shared types and constants for the stereo FIR filter with delay lines.
`timescale 1ns / 1ps
package sfdl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 40;
  localparam int DELAY_W  = 9;

  // Request kinds carried in the mode field.
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_DELAY  = 2'd2;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       coef_channel;
    logic [6:0]                 coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;
    logic [DELAY_W-1:0]         left_delay;
    logic [DELAY_W-1:0]         right_delay;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_t;

  // Per-cycle controls that the sequencer hands to each filter lane.
  typedef struct packed {
    logic acc_clr;
    logic rd_en;
    logic rd_last;
    logic line_we;
    logic tap_we;
  } lane_ctrl_t;

endpackage

FILE: rtl/stereo_fir_with_delay_lines.sv
// Top level of the stereo FIR filter with per-channel circular delay lines.
`timescale 1ns / 1ps
// Usage: requests arrive on the in_ channel (in_valid, in_stall, in_data) and
// filtered stereo samples leave on the out_ channel (out_valid, out_stall,
// out_data). A request is taken at a rising edge with valid high and stall low.
// A sample request writes both samples at the shared write index, then the two
// lanes run TAPS multiply-accumulates side by side, one tap per cycle, reading
// each delay line backward from its read index. Once both lanes are done the
// result is loaded into the output register, and only then is the next request
// taken, so a new sample waits until the last one's result is loaded.
// A coefficient write request completes as it is taken and returns nothing. A
// delay change request keeps in_stall high while ST_DMOD reduces both delays
// modulo LINE_DEPTH by repeated subtraction and ST_DAPPLY moves the read
// indices, and returns nothing. After reset a clearing pass zeroes both delay
// lines and both tap memories, one address a cycle, up to the last address of
// the larger one; in_stall stays high during that pass. When the receiver
// stalls, the result waits in the output register; the block still takes the
// next request and finishes its sums, then holds until that register is free.
module stereo_fir_with_delay_lines #(
  parameter int LINE_DEPTH = 512,
  parameter int TAPS = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sfdl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sfdl_pkg::out_t out_data
);
  import sfdl_pkg::*;

  localparam int LW = $clog2(LINE_DEPTH);
  localparam int TW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CLR_LEN = (LINE_DEPTH > TAPS) ? LINE_DEPTH : TAPS;
  localparam int CW = $clog2(CLR_LEN);
  localparam logic [LW-1:0] LAST_POS = LW'(LINE_DEPTH - 1);
  localparam logic [TW-1:0] LAST_TAP = TW'(TAPS - 1);
  localparam logic [CW-1:0] LAST_CLR = CW'(CLR_LEN - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_RUN    = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DMOD   = 6'b010000,
    ST_DAPPLY = 6'b100000
  } state_t;

  // Move a read index back by the change of delay, everything modulo the depth.
  function automatic logic [LW-1:0] shift_back(input logic [LW-1:0] rd,
                                               input logic [LW-1:0] prev,
                                               input logic [LW-1:0] nxt);
    logic [LW:0] d, r, p, n, diff, res;
    d = (LW+1)'(LINE_DEPTH);
    r = {1'b0, rd};
    p = {1'b0, prev};
    n = {1'b0, nxt};
    diff = (n >= p) ? n - p : n + d - p;
    res  = (r >= diff) ? r - diff : r + d - diff;
    return res[LW-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [TW-1:0] tap_cnt_r, tap_cnt_nxt;
  logic [LW-1:0] pos_l_r, pos_l_nxt, pos_rt_r, pos_rt_nxt;
  logic [LW-1:0] wr_idx_r, wr_idx_nxt;
  logic [LW-1:0] rd_idx_l_r, rd_idx_l_nxt, rd_idx_rt_r, rd_idx_rt_nxt;
  logic [LW-1:0] prev_l_r, prev_l_nxt, prev_rt_r, prev_rt_nxt;
  logic [DELAY_W-1:0] dly_l_r, dly_l_nxt, dly_rt_r, dly_rt_nxt;

  logic accept, clearing, coef_ok, out_load, can_load;
  logic done_left, done_right;
  logic signed [ACC_W-1:0] acc_left, acc_right;
  lane_ctrl_t ctrl_l, ctrl_rt;
  logic [LW-1:0] line_waddr;
  logic [TW-1:0] tap_waddr;
  logic signed [SAMPLE_W-1:0] wdata_l, wdata_rt, tap_wdata;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign clearing = (state_r == ST_CLEAR);
  // Taps at or above TAPS are silently dropped.
  assign coef_ok  = (32'(in_data.coef_index) < TAPS);

  // Write ports: zeroes during the clearing pass, request data otherwise.
  always_comb begin
    line_waddr = clearing ? clr_cnt_r[LW-1:0] : wr_idx_r;
    tap_waddr  = clearing ? clr_cnt_r[TW-1:0] : TW'(in_data.coef_index);
    wdata_l    = clearing ? '0 : in_data.left_sample;
    wdata_rt   = clearing ? '0 : in_data.right_sample;
    tap_wdata  = clearing ? '0 : in_data.coef_value;

    ctrl_l.acc_clr = accept && (in_data.mode == MODE_SAMPLE);
    ctrl_l.rd_en   = (state_r == ST_RUN);
    ctrl_l.rd_last = (tap_cnt_r == LAST_TAP);
    ctrl_l.line_we = (clearing && (32'(clr_cnt_r) < LINE_DEPTH)) ||
                     (accept && (in_data.mode == MODE_SAMPLE));
    ctrl_l.tap_we  = (clearing && (32'(clr_cnt_r) < TAPS)) ||
                     (accept && (in_data.mode == MODE_COEF) && coef_ok &&
                      !in_data.coef_channel);

    ctrl_rt        = ctrl_l;
    ctrl_rt.tap_we = (clearing && (32'(clr_cnt_r) < TAPS)) ||
                     (accept && (in_data.mode == MODE_COEF) && coef_ok &&
                      in_data.coef_channel);
  end

  assign out_load = (state_r == ST_DRAIN) && done_left && done_right && can_load;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    tap_cnt_nxt   = tap_cnt_r;
    pos_l_nxt     = pos_l_r;
    pos_rt_nxt    = pos_rt_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_l_nxt  = rd_idx_l_r;
    rd_idx_rt_nxt = rd_idx_rt_r;
    prev_l_nxt    = prev_l_r;
    prev_rt_nxt   = prev_rt_r;
    dly_l_nxt     = dly_l_r;
    dly_rt_nxt    = dly_rt_r;

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_CLR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_SAMPLE: begin
              tap_cnt_nxt = '0;
              pos_l_nxt   = rd_idx_l_r;
              pos_rt_nxt  = rd_idx_rt_r;
              state_nxt   = ST_RUN;
            end
            MODE_DELAY: begin
              dly_l_nxt  = in_data.left_delay;
              dly_rt_nxt = in_data.right_delay;
              state_nxt  = ST_DMOD;
            end
            default: begin
              // Coefficient writes finish on the accept edge; mode 3 is ignored.
            end
          endcase
        end
      end
      ST_RUN: begin
        tap_cnt_nxt = tap_cnt_r + 1'b1;
        pos_l_nxt   = (pos_l_r == '0) ? LAST_POS : pos_l_r - 1'b1;
        pos_rt_nxt  = (pos_rt_r == '0) ? LAST_POS : pos_rt_r - 1'b1;
        if (tap_cnt_r == LAST_TAP) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          wr_idx_nxt    = (wr_idx_r == LAST_POS) ? '0 : wr_idx_r + 1'b1;
          rd_idx_l_nxt  = (rd_idx_l_r == LAST_POS) ? '0 : rd_idx_l_r + 1'b1;
          rd_idx_rt_nxt = (rd_idx_rt_r == LAST_POS) ? '0 : rd_idx_rt_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DMOD: begin
        // Reduce both delays below the depth by repeated subtraction.
        if (32'(dly_l_r) >= LINE_DEPTH) begin
          dly_l_nxt = dly_l_r - DELAY_W'(LINE_DEPTH);
        end
        if (32'(dly_rt_r) >= LINE_DEPTH) begin
          dly_rt_nxt = dly_rt_r - DELAY_W'(LINE_DEPTH);
        end
        if ((32'(dly_l_r) < LINE_DEPTH) && (32'(dly_rt_r) < LINE_DEPTH)) begin
          state_nxt = ST_DAPPLY;
        end
      end
      ST_DAPPLY: begin
        rd_idx_l_nxt  = shift_back(rd_idx_l_r, prev_l_r, LW'(dly_l_r));
        rd_idx_rt_nxt = shift_back(rd_idx_rt_r, prev_rt_r, LW'(dly_rt_r));
        prev_l_nxt    = LW'(dly_l_r);
        prev_rt_nxt   = LW'(dly_rt_r);
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      tap_cnt_r   <= '0;
      wr_idx_r    <= LW'(1);
      rd_idx_l_r  <= '0;
      rd_idx_rt_r <= '0;
      prev_l_r    <= '0;
      prev_rt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_l_r  <= rd_idx_l_nxt;
      rd_idx_rt_r <= rd_idx_rt_nxt;
      prev_l_r    <= prev_l_nxt;
      prev_rt_r   <= prev_rt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_l_r  <= pos_l_nxt;
    pos_rt_r <= pos_rt_nxt;
    dly_l_r  <= dly_l_nxt;
    dly_rt_r <= dly_rt_nxt;
  end

  sfdl_lane #(.LINE_DEPTH(LINE_DEPTH), .TAPS(TAPS)) u_lane_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_l),
    .line_waddr (line_waddr),
    .line_wdata (wdata_l),
    .line_raddr (pos_l_r),
    .tap_waddr  (tap_waddr),
    .tap_wdata  (tap_wdata),
    .tap_raddr  (tap_cnt_r),
    .acc        (acc_left),
    .done       (done_left)
  );

  sfdl_lane #(.LINE_DEPTH(LINE_DEPTH), .TAPS(TAPS)) u_lane_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_rt),
    .line_waddr (line_waddr),
    .line_wdata (wdata_rt),
    .line_raddr (pos_rt_r),
    .tap_waddr  (tap_waddr),
    .tap_wdata  (tap_wdata),
    .tap_raddr  (tap_cnt_r),
    .acc        (acc_right),
    .done       (done_right)
  );

  sfdl_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .acc_left  (acc_left),
    .acc_right (acc_right),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // Both lanes share one sequencer, so their sums must finish together.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    done_left == done_right)
    else $error("filter lanes out of step");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !out_load)
    else $error("output register overwritten while stalled");

  // A sample request starts the tap sweep at tap zero.
  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.mode == MODE_SAMPLE)) |=> (state_r == ST_RUN && tap_cnt_r == '0))
    else $error("tap sweep did not start at tap zero");

  // Circular indices stay inside the delay line.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(wr_idx_r) < LINE_DEPTH) && (32'(rd_idx_l_r) < LINE_DEPTH) &&
    (32'(rd_idx_rt_r) < LINE_DEPTH))
    else $error("delay line index out of range");
`endif

endmodule

FILE: rtl/sfdl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module sfdl_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/sfdl_lane.sv
// One filter lane: delay line, tap memory and a multiply-accumulate pipeline.
`timescale 1ns / 1ps
module sfdl_lane #(
  parameter int LINE_DEPTH = 512,
  parameter int TAPS = 128,
  localparam int LW = $clog2(LINE_DEPTH),
  localparam int TW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sfdl_pkg::lane_ctrl_t                ctrl,
  input  logic [LW-1:0]                       line_waddr,
  input  logic signed [sfdl_pkg::SAMPLE_W-1:0] line_wdata,
  input  logic [LW-1:0]                       line_raddr,
  input  logic [TW-1:0]                       tap_waddr,
  input  logic signed [sfdl_pkg::SAMPLE_W-1:0] tap_wdata,
  input  logic [TW-1:0]                       tap_raddr,
  output logic signed [sfdl_pkg::ACC_W-1:0]    acc,
  output logic                                done
);
  import sfdl_pkg::*;

  logic signed [SAMPLE_W-1:0] line_q;
  logic signed [SAMPLE_W-1:0] tap_q;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic v1_r, v2_r, l1_r, l2_r, done_r;

  sfdl_ram #(.DEPTH(LINE_DEPTH), .WIDTH(SAMPLE_W)) u_line (
    .clk   (clk),
    .we    (ctrl.line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_q)
  );

  sfdl_ram #(.DEPTH(TAPS), .WIDTH(SAMPLE_W)) u_taps (
    .clk   (clk),
    .we    (ctrl.tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (tap_raddr),
    .rdata (tap_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      l1_r   <= 1'b0;
      l2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r <= ctrl.rd_en;
      l1_r <= ctrl.rd_en & ctrl.rd_last;
      v2_r <= v1_r;
      l2_r <= l1_r;
      if (ctrl.acc_clr) begin
        done_r <= 1'b0;
      end else if (v2_r && l2_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // With at most 128 nonzero taps the sum stays far inside 40 bits.
  always_ff @(posedge clk) begin
    prod_r <= line_q * tap_q;
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

FILE: rtl/sfdl_merge.sv
// Output stage: scales and saturates both lane sums into the result register.
`timescale 1ns / 1ps
module sfdl_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic signed [sfdl_pkg::ACC_W-1:0] acc_left,
  input  logic signed [sfdl_pkg::ACC_W-1:0] acc_right,
  output logic                             can_load,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sfdl_pkg::out_t                   out_data
);
  import sfdl_pkg::*;

  // Arithmetic shift gives the floor; then clamp to the Q1.15 range.
  function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = a >>> 15;
    if (s > 40'sd32767) begin
      return 16'sh7fff;
    end else if (s < -40'sd32768) begin
      return 16'sh8000;
    end
    return s[SAMPLE_W-1:0];
  endfunction

  logic valid_r;
  out_t data_r;

  assign can_load = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r.left_out  <= sat_q15(acc_left);
      data_r.right_out <= sat_q15(acc_right);
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: dv/stereo_fir_with_delay_lines_tb.sv
// Self-checking testbench for the stereo FIR filter with per-channel delay lines.
`timescale 1ns / 1ps
module stereo_fir_with_delay_lines_tb;
  import sfdl_pkg::*;

  localparam int LINE_DEPTH = 512;
  localparam int TAPS = 128;
  localparam int RANDOM_REQUESTS = 950;
  // The mode value that no request kind uses.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // The limit leaves ample margin for the slowest legal run, with the longest
  // sender gaps and receiver stalls on every request.
  localparam int CYCLE_LIMIT = 3000000;
  // Twice the span of one sample request plus slack covers anything that is
  // still in flight when the last result has been seen.
  localparam int DRAIN_CYCLES = 2 * (TAPS + 4) + 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  stereo_fir_with_delay_lines #(
    .LINE_DEPTH(LINE_DEPTH),
    .TAPS(TAPS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be driven, and filtered samples the block still owes us.
  in_t request_q[$];
  out_t filtered_q[$];
  int requests_total = 0;
  int requests_accepted = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // Shadow copy of the filter state: delay lines, tap memory, indices, delays.
  logic signed [15:0] shadow_left_line [LINE_DEPTH];
  logic signed [15:0] shadow_right_line [LINE_DEPTH];
  logic signed [15:0] shadow_taps [2][TAPS];
  int unsigned shadow_write_idx;
  int unsigned shadow_left_rd;
  int unsigned shadow_right_rd;
  int unsigned shadow_left_delay;
  int unsigned shadow_right_delay;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH cycle %0d: %s got %h wanted %h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // One channel's FIR sum: TAPS products read backward from the read index.
  // The exact sum never exceeds 2^37, so the 40-bit accumulator cannot clip and
  // only the floor shift and the 16-bit saturation matter.
  function automatic logic signed [15:0] fir_sum(input bit right_ch, input int unsigned rd);
    longint acc;
    int unsigned pos;
    logic signed [15:0] smp;
    acc = 0;
    pos = rd % LINE_DEPTH;
    for (int i = 0; i < TAPS; i++) begin
      smp = right_ch ? shadow_right_line[pos] : shadow_left_line[pos];
      acc += longint'(smp) * longint'(shadow_taps[right_ch][i]);
      pos = (pos == 0) ? LINE_DEPTH - 1 : pos - 1;
    end
    // Arithmetic shift of a signed value rounds toward minus infinity.
    acc = acc >>> 15;
    if (acc > 32767) return 16'sh7fff;
    if (acc < -32768) return 16'sh8000;
    return acc[15:0];
  endfunction

  // Moves a read index back by the change in delay, all modulo the depth.
  function automatic int unsigned shifted_read(input int unsigned rd, input int unsigned prev,
                                               input int unsigned nxt);
    int unsigned diff;
    diff = (nxt % LINE_DEPTH + LINE_DEPTH - prev % LINE_DEPTH) % LINE_DEPTH;
    return (rd % LINE_DEPTH + LINE_DEPTH - diff) % LINE_DEPTH;
  endfunction

  // Applies one accepted request to the shadow state and queues any result it has.
  function automatic void predict_filter_output(input in_t req);
    out_t res;
    case (req.mode)
      MODE_SAMPLE: begin
        // Samples go in first; the sums then use the read indices as they stand.
        shadow_left_line[shadow_write_idx] = req.left_sample;
        shadow_right_line[shadow_write_idx] = req.right_sample;
        res.left_out = fir_sum(1'b0, shadow_left_rd);
        res.right_out = fir_sum(1'b1, shadow_right_rd);
        filtered_q.push_back(res);
        shadow_write_idx = (shadow_write_idx + 1) % LINE_DEPTH;
        shadow_left_rd = (shadow_left_rd + 1) % LINE_DEPTH;
        shadow_right_rd = (shadow_right_rd + 1) % LINE_DEPTH;
      end
      MODE_COEF: begin
        if (req.coef_index < TAPS) shadow_taps[req.coef_channel][req.coef_index] = req.coef_value;
      end
      MODE_DELAY: begin
        shadow_left_rd = shifted_read(shadow_left_rd, shadow_left_delay,
                                      32'(req.left_delay));
        shadow_right_rd = shifted_read(shadow_right_rd, shadow_right_delay,
                                       32'(req.right_delay));
        shadow_left_delay = 32'(req.left_delay);
        shadow_right_delay = 32'(req.right_delay);
      end
      default: begin
        // The unused mode leaves every piece of state alone.
      end
    endcase
  endfunction

  // Every field gets random bits, so fields a mode does not use still toggle.
  function automatic in_t random_request();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic in_t sample_request(input logic signed [15:0] l,
                                         input logic signed [15:0] r);
    in_t req;
    req = random_request();
    req.mode = MODE_SAMPLE;
    req.left_sample = l;
    req.right_sample = r;
    return req;
  endfunction

  function automatic in_t coef_request(input logic ch, input logic [6:0] idx,
                                       input logic signed [15:0] val);
    in_t req;
    req = random_request();
    req.mode = MODE_COEF;
    req.coef_channel = ch;
    req.coef_index = idx;
    req.coef_value = val;
    return req;
  endfunction

  function automatic in_t delay_request(input logic [8:0] l, input logic [8:0] r);
    in_t req;
    req = random_request();
    req.mode = MODE_DELAY;
    req.left_delay = l;
    req.right_delay = r;
    return req;
  endfunction

  // Samples lean on the rails now and then so saturation and sign edges show up.
  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 63) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  // Coefficients stay mostly small; full-scale, random and zero ones come now and then.
  function automatic logic signed [15:0] random_coef();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom());
      3: return 16'sh0000;
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  function automatic logic [8:0] random_delay();
    case ($urandom_range(0, 5))
      0: return 9'd0;
      1: return 9'd511;
      2: return 9'($urandom_range(0, 8));
      default: return 9'($urandom());
    endcase
  endfunction

  // Sender: random-length bursts with random gaps between. A request stays on
  // in_data until taken; the next follows at once unless a gap is due.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_filter_output(in_data);
        requests_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= request_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            // Many bursts follow back to back; a few gaps outlast a whole tap loop.
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              3: gap_left = $urandom_range(100, 300);
              default: gap_left = $urandom_range(1, 20);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: runs of no stall, short random flicker, and long solid stalls.
  int stall_run = 0;
  int unsigned stall_pick;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run == 0) begin
      stall_pick = $urandom_range(0, 9);
      if (stall_pick < 4) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(1, 300);
      end else if (stall_pick < 8) begin
        out_stall <= 1'($urandom_range(0, 1));
        stall_run <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(1, 150);
      end
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // Monitor: every accepted result is checked against the oldest prediction.
  out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("left_out with no result pending", out_data.left_out, 16'h0000);
      end else begin
        want = filtered_q.pop_front();
        if (out_data.left_out !== want.left_out)
          report_mismatch("left_out", out_data.left_out, want.left_out);
        if (out_data.right_out !== want.right_out)
          report_mismatch("right_out", out_data.right_out, want.right_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int counted;
    int unsigned pick;
    in_t req;

    // Shadow state after reset: lines and taps zero, write index one ahead.
    foreach (shadow_left_line[i]) begin
      shadow_left_line[i] = '0;
      shadow_right_line[i] = '0;
    end
    foreach (shadow_taps[c, t]) shadow_taps[c][t] = '0;
    shadow_write_idx = 1 % LINE_DEPTH;
    shadow_left_rd = 0;
    shadow_right_rd = 0;
    shadow_left_delay = 0;
    shadow_right_delay = 0;

    // Directed part. With all taps zero the output must be zero even at the rails.
    request_q.push_back(sample_request(16'sh7fff, 16'sh8000));
    // Extreme coefficients at the first and the last tap of both channels.
    request_q.push_back(coef_request(1'b0, 7'd0, 16'sh7fff));
    request_q.push_back(coef_request(1'b1, 7'd0, 16'sh8000));
    request_q.push_back(coef_request(1'b0, 7'd127, 16'sh8000));
    request_q.push_back(coef_request(1'b1, 7'd127, 16'sh7fff));
    request_q.push_back(sample_request(16'sh7fff, 16'sh8000));
    request_q.push_back(sample_request(16'sh8000, 16'sh7fff));
    // Small odd values make the floor of negative sums visible.
    request_q.push_back(sample_request(-16'sd1, 16'sd1));
    request_q.push_back(sample_request(16'sd1, -16'sd1));
    // Two full-scale negative taps with negative rails overflow 16 bits.
    request_q.push_back(coef_request(1'b0, 7'd1, 16'sh8000));
    request_q.push_back(coef_request(1'b1, 7'd1, 16'sh8000));
    request_q.push_back(coef_request(1'b0, 7'd0, 16'sh8000));
    request_q.push_back(sample_request(16'sh8000, 16'sh8000));
    request_q.push_back(sample_request(16'sh8000, 16'sh8000));
    request_q.push_back(sample_request(16'sh7fff, 16'sh7fff));
    // Delay changes at both extremes, including a step back down to zero.
    request_q.push_back(delay_request(9'd511, 9'd0));
    request_q.push_back(sample_request(16'sh1234, -16'sh1234));
    request_q.push_back(delay_request(9'd0, 9'd511));
    request_q.push_back(sample_request(16'sh7fff, 16'sh8000));
    request_q.push_back(delay_request(9'd0, 9'd0));
    // The unused mode must change nothing and return nothing.
    req = random_request();
    req.mode = MODE_UNUSED;
    request_q.push_back(req);
    request_q.push_back(sample_request(16'sh0100, 16'sh0100));

    // Random part, mostly samples mixed with coefficient loads and delay moves.
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        request_q.push_back(sample_request(random_sample(), random_sample()));
      end else if (pick < 17) begin
        request_q.push_back(coef_request(1'($urandom_range(0, 1)),
                                         7'($urandom_range(0, 127)), random_coef()));
      end else if (pick < 19) begin
        request_q.push_back(delay_request(random_delay(), random_delay()));
      end else begin
        req = random_request();
        req.mode = MODE_UNUSED;
        request_q.push_back(req);
      end
      counted++;
    end
    requests_total = request_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken, then for every result to come back,
    // then a little longer so a stray extra result would still be caught.
    while (requests_accepted < requests_total) @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sfdl_pkg.sv
rtl/sfdl_ram.sv
rtl/sfdl_lane.sv
rtl/sfdl_merge.sv
rtl/stereo_fir_with_delay_lines.sv
dv/stereo_fir_with_delay_lines_tb.sv
